### src/prlm_pkg.sv
// Shared types, codes and helpers for the port request link monitor.
`timescale 1ns / 1ps
`default_nettype none

package prlm_pkg;

    // Default limits
    localparam int RESPONSE_MAX_DEF = 18;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // Transaction operation codes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_EDGE  = 3'd1;
    localparam logic [2:0] OP_BYTE  = 3'd2;
    localparam logic [2:0] OP_ARM   = 3'd3;
    localparam logic [2:0] OP_STATS = 3'd4;

    // Classified command kinds handed from front to back
    localparam logic [2:0] KIND_NOP   = 3'd0;
    localparam logic [2:0] KIND_TICK  = 3'd1;
    localparam logic [2:0] KIND_EDGE  = 3'd2;
    localparam logic [2:0] KIND_BYTE  = 3'd3;
    localparam logic [2:0] KIND_ARM   = 3'd4;
    localparam logic [2:0] KIND_STATS = 3'd5;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_RECEIVE_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MS      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HB_TIMEOUT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_BYTE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ALLOW_HANDOFF  = 3'd5;

    // Configuration reset values
    localparam logic [15:0] WINDOW_MS_RST      = 16'd200;
    localparam logic [7:0]  EDGE_THRESHOLD_RST = 8'd2;
    localparam logic [15:0] HB_TIMEOUT_RST     = 16'd300;
    localparam logic [7:0]  TICKS_PER_BYTE_RST = 8'd1;

    // Heartbeat frame and CRC polynomial
    localparam logic [7:0] HB_BYTE0 = 8'hC1;
    localparam logic [7:0] HB_BYTE1 = 8'h14;
    localparam logic [7:0] HB_BYTE2 = 8'h01;
    localparam logic [7:0] HB_BYTE3 = 8'hA5;
    localparam logic [7:0] CRC_POLY = 8'h07;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic       byte_corrupt;
        logic [4:0] response_length;
    } item_t;

    typedef struct packed {
        logic       port_requested;
        logic       port_to_partner;
        logic       byte_valid;
        logic [7:0] response_byte;
        logic       response_last;
        logic       crc_bad;
        logic       timed_out;
        logic       arm_refused;
        logic [7:0] ok_count;
        logic [7:0] crc_fail_count;
        logic [7:0] timeout_count;
    } result_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       byte_corrupt;
        logic [4:0] length;
        logic       length_ok;
    } cmd_t;

    // One byte of CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] hb_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = HB_BYTE0;
            2'd1:    b = HB_BYTE1;
            2'd2:    b = HB_BYTE2;
            default: b = HB_BYTE3;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### src/port_request_link_monitor_core.sv
// Top level of the port request link monitor.
//
// Input side is a queue: drive item and push; the transaction is taken at a
// clock edge with push high and full low. Result side is a queue too: the
// oldest result sits on result while empty is low and is taken at an edge
// with pop high. Every input transaction yields exactly one result.
// Configuration: cfg_write_en with cfg_index/cfg_data writes one register in
// that cycle; write only while no transaction is in flight.
// Path: a taken transaction is stored in the command queue; the back end then
// writes its result into the result queue when that queue has room. Throughput:
// one transaction per cycle while the result queue has room, set by the back end.
// Front end classifies into a two-entry command queue; the back end updates
// the monitor state and writes a two-entry result queue.
// Reset clears both queues, all counters and ownership, and loads the
// register defaults (edge mode, 200-tick window, threshold 2, 300-tick
// heartbeat timeout, one tick per byte, no handoff).
// When pop stays low the result queue fills, the back end holds, the command
// queue fills and full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module port_request_link_monitor_core #(
    parameter int RESPONSE_MAX = prlm_pkg::RESPONSE_MAX_DEF,
    parameter int QUEUE_DEPTH  = prlm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [prlm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [prlm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             push,
    input  wire prlm_pkg::item_t                  item,
    output logic                                  full,
    output logic                                  empty,
    input  wire logic                             pop,
    output prlm_pkg::result_t                     result
);

    import prlm_pkg::*;

    cmd_t    cmd;
    logic    cmd_valid;
    logic    cmd_pop;
    result_t res;
    logic    res_push;
    logic    res_full;

    prlm_front #(
        .RESPONSE_MAX (RESPONSE_MAX),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    prlm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .res          (res),
        .res_push     (res_push),
        .res_full     (res_full)
    );

    prlm_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

### src/prlm_queue.sv
// Small synchronous FIFO used between the front, the back and the result port.
`timescale 1ns / 1ps
`default_nettype none

module prlm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

### src/prlm_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module prlm_front #(
    parameter int RESPONSE_MAX = prlm_pkg::RESPONSE_MAX_DEF,
    parameter int QUEUE_DEPTH  = prlm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire prlm_pkg::item_t item,
    output logic                 full,
    output prlm_pkg::cmd_t       cmd,
    output logic                 cmd_valid,
    input  wire logic            cmd_pop
);

    import prlm_pkg::*;

    cmd_t cmd_in;
    logic cmd_empty;

    always_comb
    begin
        cmd_in.data_byte    = item.data_byte;
        cmd_in.byte_corrupt = item.byte_corrupt;
        cmd_in.length       = item.response_length;
        cmd_in.length_ok    = (item.response_length <= 5'(RESPONSE_MAX));
        unique case (item.operation)
            OP_TICK:  cmd_in.kind = KIND_TICK;
            OP_EDGE:  cmd_in.kind = KIND_EDGE;
            OP_BYTE:  cmd_in.kind = KIND_BYTE;
            OP_ARM:   cmd_in.kind = KIND_ARM;
            OP_STATS: cmd_in.kind = KIND_STATS;
            default:  cmd_in.kind = KIND_NOP;
        endcase
    end

    prlm_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd),
        .empty (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

### src/prlm_back.sv
// Back end: configuration registers, monitor state and one command per cycle while the result queue has room.
`timescale 1ns / 1ps
`default_nettype none

module prlm_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write_en,
    input  wire logic [prlm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [prlm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire prlm_pkg::cmd_t                     cmd,
    input  wire logic                               cmd_valid,
    output logic                                    cmd_pop,
    output prlm_pkg::result_t                       res,
    output logic                                    res_push,
    input  wire logic                               res_full
);

    import prlm_pkg::*;

    // Configuration
    logic        receive_mode_reg;
    logic [15:0] window_ms_reg;
    logic [7:0]  edge_threshold_reg;
    logic [15:0] hb_timeout_reg;
    logic [7:0]  ticks_per_byte_reg;
    logic        allow_handoff_reg;

    // Monitor state
    logic [15:0] edge_count_reg, edge_count_next;
    logic [15:0] window_count_reg, window_count_next;
    logic [15:0] window_elapsed_reg, window_elapsed_next;
    logic [1:0]  pattern_pos_reg, pattern_pos_next;
    logic        hb_seen_reg, hb_seen_next;
    logic [15:0] hb_age_reg, hb_age_next;
    logic [4:0]  expected_reg, expected_next;
    logic [4:0]  captured_reg, captured_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] deadline_reg, deadline_next;
    logic [7:0]  good_reg, good_next;
    logic [7:0]  crc_fail_reg, crc_fail_next;
    logic [7:0]  timeouts_reg, timeouts_next;
    logic        owner_reg, owner_next;

    logic        step;
    logic        requested;
    logic [5:0]  len_plus2;
    logic [13:0] deadline_prod;
    logic [15:0] deadline_load;
    logic [4:0]  captured_inc;
    logic [15:0] deadline_dec;

    assign step     = cmd_valid && !res_full;
    assign cmd_pop  = step;
    assign res_push = step;

    assign len_plus2     = {1'b0, cmd.length} + 6'd2;
    assign deadline_prod = {8'd0, len_plus2} * {6'd0, ticks_per_byte_reg};
    assign deadline_load = {2'b00, deadline_prod} + 16'd1;
    assign captured_inc  = captured_reg + 5'd1;
    assign deadline_dec  = (deadline_reg != 16'd0) ? deadline_reg - 16'd1 : 16'd0;

    always_comb
    begin
        edge_count_next     = edge_count_reg;
        window_count_next   = window_count_reg;
        window_elapsed_next = window_elapsed_reg;
        pattern_pos_next    = pattern_pos_reg;
        hb_seen_next        = hb_seen_reg;
        hb_age_next         = hb_age_reg;
        expected_next       = expected_reg;
        captured_next       = captured_reg;
        crc_next            = crc_reg;
        deadline_next       = deadline_reg;
        good_next           = good_reg;
        crc_fail_next       = crc_fail_reg;
        timeouts_next       = timeouts_reg;
        owner_next          = owner_reg;
        res                 = '0;

        unique case (cmd.kind)
            KIND_TICK:
            begin
                window_elapsed_next = (window_elapsed_reg != 16'hFFFF)
                                    ? window_elapsed_reg + 16'd1 : window_elapsed_reg;
                hb_age_next = (hb_age_reg != 16'hFFFF) ? hb_age_reg + 16'd1 : hb_age_reg;
                if (!receive_mode_reg && (window_elapsed_next >= window_ms_reg))
                begin
                    // close the window and latch its edge count
                    window_count_next   = edge_count_reg;
                    edge_count_next     = 16'd0;
                    window_elapsed_next = 16'd0;
                end
                if (expected_reg != 5'd0)
                begin
                    deadline_next = deadline_dec;
                    if (deadline_dec == 16'd0)
                    begin
                        expected_next = 5'd0;
                        timeouts_next = (timeouts_reg != 8'hFF) ? timeouts_reg + 8'd1
                                                                : timeouts_reg;
                        res.timed_out = 1'b1;
                    end
                end
            end
            KIND_EDGE:
            begin
                if (!receive_mode_reg && (edge_count_reg != 16'hFFFF))
                begin
                    edge_count_next = edge_count_reg + 16'd1;
                end
            end
            KIND_BYTE:
            begin
                if (receive_mode_reg)
                begin
                    if (cmd.byte_corrupt)
                    begin
                        pattern_pos_next = 2'd0;
                    end
                    else if (expected_reg != 5'd0)
                    begin
                        captured_next     = captured_inc;
                        res.byte_valid    = 1'b1;
                        res.response_byte = cmd.data_byte;
                        if (captured_inc >= expected_reg)
                        begin
                            res.response_last = 1'b1;
                            if ((expected_reg >= 5'd2) && (crc_reg != cmd.data_byte))
                            begin
                                res.crc_bad   = 1'b1;
                                crc_fail_next = (crc_fail_reg != 8'hFF) ? crc_fail_reg + 8'd1
                                                                        : crc_fail_reg;
                            end
                            else
                            begin
                                good_next = (good_reg != 8'hFF) ? good_reg + 8'd1 : good_reg;
                            end
                            expected_next = 5'd0;
                        end
                        else
                        begin
                            crc_next = crc8_step(crc_reg, cmd.data_byte);
                        end
                    end
                    else if (cmd.data_byte == hb_byte(pattern_pos_reg))
                    begin
                        pattern_pos_next = pattern_pos_reg + 2'd1;
                        if (pattern_pos_reg == 2'd3)
                        begin
                            hb_seen_next = 1'b1;
                            hb_age_next  = 16'd0;
                        end
                    end
                    else
                    begin
                        // a mismatching byte may still open a new frame
                        pattern_pos_next = (cmd.data_byte == HB_BYTE0) ? 2'd1 : 2'd0;
                    end
                end
            end
            KIND_ARM:
            begin
                if (!receive_mode_reg || !cmd.length_ok)
                begin
                    res.arm_refused = 1'b1;
                end
                else if (cmd.length == 5'd0)
                begin
                    expected_next = 5'd0;
                    good_next     = (good_reg != 8'hFF) ? good_reg + 8'd1 : good_reg;
                end
                else
                begin
                    expected_next = cmd.length;
                    captured_next = 5'd0;
                    crc_next      = 8'd0;
                    deadline_next = deadline_load;
                end
            end
            KIND_STATS:
            begin
                res.ok_count       = good_reg;
                res.crc_fail_count = crc_fail_reg;
                res.timeout_count  = timeouts_reg;
                good_next          = 8'd0;
                crc_fail_next      = 8'd0;
                timeouts_next      = 8'd0;
            end
            default:
            begin
            end
        endcase

        requested = receive_mode_reg ? (hb_seen_next && (hb_age_next < hb_timeout_reg))
                                     : (window_count_next > {8'd0, edge_threshold_reg});

        // ownership moves only on ticks: every tick in byte mode, window close in edge mode
        if ((cmd.kind == KIND_TICK) &&
            (receive_mode_reg || (window_elapsed_next == 16'd0)))
        begin
            if (!requested)
            begin
                owner_next = 1'b0;
            end
            else if (allow_handoff_reg)
            begin
                owner_next = 1'b1;
            end
        end

        res.port_requested  = requested;
        res.port_to_partner = owner_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receive_mode_reg   <= 1'b0;
            window_ms_reg      <= WINDOW_MS_RST;
            edge_threshold_reg <= EDGE_THRESHOLD_RST;
            hb_timeout_reg     <= HB_TIMEOUT_RST;
            ticks_per_byte_reg <= TICKS_PER_BYTE_RST;
            allow_handoff_reg  <= 1'b0;
            edge_count_reg     <= '0;
            window_count_reg   <= '0;
            window_elapsed_reg <= '0;
            pattern_pos_reg    <= '0;
            hb_seen_reg        <= 1'b0;
            hb_age_reg         <= '0;
            expected_reg       <= '0;
            captured_reg       <= '0;
            crc_reg            <= '0;
            deadline_reg       <= '0;
            good_reg           <= '0;
            crc_fail_reg       <= '0;
            timeouts_reg       <= '0;
            owner_reg          <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            // the user must write configuration only while the datapath is idle; the block does not enforce it
            unique case (cfg_index)
                REG_RECEIVE_MODE:
                begin
                    receive_mode_reg   <= cfg_data[0];
                    edge_count_reg     <= '0;
                    window_count_reg   <= '0;
                    window_elapsed_reg <= '0;
                    pattern_pos_reg    <= '0;
                    hb_seen_reg        <= 1'b0;
                end
                REG_WINDOW_MS:      window_ms_reg      <= cfg_data;
                REG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[7:0];
                REG_HB_TIMEOUT:     hb_timeout_reg     <= cfg_data;
                REG_TICKS_PER_BYTE: ticks_per_byte_reg <= cfg_data[7:0];
                REG_ALLOW_HANDOFF:  allow_handoff_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
        else if (step)
        begin
            edge_count_reg     <= edge_count_next;
            window_count_reg   <= window_count_next;
            window_elapsed_reg <= window_elapsed_next;
            pattern_pos_reg    <= pattern_pos_next;
            hb_seen_reg        <= hb_seen_next;
            hb_age_reg         <= hb_age_next;
            expected_reg       <= expected_next;
            captured_reg       <= captured_next;
            crc_reg            <= crc_next;
            deadline_reg       <= deadline_next;
            good_reg           <= good_next;
            crc_fail_reg       <= crc_fail_next;
            timeouts_reg       <= timeouts_next;
            owner_reg          <= owner_next;
        end
    end

endmodule

`default_nettype wire

### src/prlm_checker.sv
// Port-level checks for the port request link monitor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module prlm_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              empty,
    input wire logic              pop,
    input wire prlm_pkg::result_t result
);

    import prlm_pkg::*;

    // a waiting result holds until popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed or vanished while not popped");

    // a result comes from one operation only
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ($countones({result.byte_valid, result.timed_out, result.arm_refused}) <= 1))
        else $error("result mixes byte, timeout and arm flags");

    a_last_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.response_last) |-> result.byte_valid)
        else $error("response_last without a captured byte");

    a_crc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.crc_bad) |-> result.response_last)
        else $error("crc_bad outside the final response byte");

endmodule

bind port_request_link_monitor_core prlm_checker u_prlm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the port request link monitor core.
`timescale 1ns / 1ps

module testbench;
    import prlm_pkg::*;

    localparam int CLK_HALF_NS = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_AT_ITEM = 50;
    localparam int HOLD_CYCLES = 160;
    localparam int REPORT_LIMIT = 10;
    localparam longint RUN_LIMIT_NS = 5_000_000;
    localparam logic [3:0][7:0] HEARTBEAT = {HB_BYTE3, HB_BYTE2, HB_BYTE1, HB_BYTE0};

    typedef struct packed {
        logic                   is_reg;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        item_t                  stim;
        logic                   typed;
        result_t                want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   push = 1'b0;
    item_t                  item = '0;
    logic                   full;
    logic                   empty;
    logic                   pop = 1'b0;
    result_t                result;

    // register copies
    logic        mode_bytes;
    logic [15:0] window_len;
    logic [7:0]  edge_limit;
    logic [15:0] hb_limit;
    logic [7:0]  byte_ticks;
    logic        handoff_ok;

    // monitor state copies
    logic [15:0] edges_open;
    logic [15:0] edges_closed;
    logic [15:0] window_age;
    logic [1:0]  hb_pos;
    logic        hb_valid;
    logic [15:0] hb_age;
    logic [4:0]  resp_len;
    logic [4:0]  resp_got;
    logic [7:0]  resp_crc;
    logic [15:0] resp_deadline;
    logic [7:0]  ok_total;
    logic [7:0]  crc_fail_total;
    logic [7:0]  timeout_total;
    logic        partner_owns;

    result_t  expected_results[$];
    result_t  popped_want;
    dir_row_t directed[$];
    result_t  refused;
    result_t  handed;
    int       link_errors = 0;
    int       items_sent = 0;
    int       burst_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       rx_style = 0;
    int       rx_phase_left = 0;

    port_request_link_monitor_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .item        (item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

    always #CLK_HALF_NS clk = ~clk;

    function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        return c;
    endfunction

    function automatic logic link_requested();
        if (mode_bytes)
            return hb_valid && (hb_age < hb_limit);
        return edges_closed > {8'd0, edge_limit};
    endfunction

    function automatic void settle_owner();
        if (!link_requested())
            partner_owns = 1'b0;
        else if (handoff_ok)
            partner_owns = 1'b1;
    endfunction

    function automatic result_t predict_link(item_t it);
        result_t r;
        int      span;
        r = '0;
        case (it.operation)
            OP_TICK:
            begin
                if (window_age != 16'hFFFF)
                    window_age = window_age + 16'd1;
                if (hb_age != 16'hFFFF)
                    hb_age = hb_age + 16'd1;
                if (!mode_bytes)
                begin
                    if (window_age >= window_len)
                    begin
                        edges_closed = edges_open;
                        edges_open = '0;
                        window_age = '0;
                        settle_owner();
                    end
                end
                else
                    settle_owner();
                if (resp_len != 0)
                begin
                    if (resp_deadline != 0)
                        resp_deadline = resp_deadline - 16'd1;
                    if (resp_deadline == 0)
                    begin
                        resp_len = '0;
                        if (timeout_total != 8'hFF)
                            timeout_total = timeout_total + 8'd1;
                        r.timed_out = 1'b1;
                    end
                end
            end
            OP_EDGE:
                if (!mode_bytes && edges_open != 16'hFFFF)
                    edges_open = edges_open + 16'd1;
            OP_BYTE:
                if (mode_bytes)
                begin
                    if (it.byte_corrupt)
                        hb_pos = '0;
                    else if (resp_len != 0)
                    begin
                        resp_got = resp_got + 5'd1;
                        r.byte_valid = 1'b1;
                        r.response_byte = it.data_byte;
                        if (resp_got >= resp_len)
                        begin
                            r.response_last = 1'b1;
                            if (resp_len >= 2 && resp_crc != it.data_byte)
                            begin
                                r.crc_bad = 1'b1;
                                if (crc_fail_total != 8'hFF)
                                    crc_fail_total = crc_fail_total + 8'd1;
                            end
                            else if (ok_total != 8'hFF)
                                ok_total = ok_total + 8'd1;
                            resp_len = '0;
                        end
                        else
                            resp_crc = crc8_update(resp_crc, it.data_byte);
                    end
                    else if (it.data_byte == HEARTBEAT[hb_pos])
                    begin
                        if (hb_pos == 2'd3)
                        begin
                            hb_pos = '0;
                            hb_valid = 1'b1;
                            hb_age = '0;
                        end
                        else
                            hb_pos = hb_pos + 2'd1;
                    end
                    else
                        hb_pos = (it.data_byte == HB_BYTE0) ? 2'd1 : 2'd0;
                end
            OP_ARM:
                if (!mode_bytes || it.response_length > RESPONSE_MAX_DEF)
                    r.arm_refused = 1'b1;
                else if (it.response_length == 0)
                begin
                    resp_len = '0;
                    if (ok_total != 8'hFF)
                        ok_total = ok_total + 8'd1;
                end
                else
                begin
                    resp_len = it.response_length;
                    resp_got = '0;
                    resp_crc = '0;
                    span = 1 + (int'(it.response_length) + 2) * int'(byte_ticks);
                    resp_deadline = span[15:0];
                end
            OP_STATS:
            begin
                r.ok_count = ok_total;
                r.crc_fail_count = crc_fail_total;
                r.timeout_count = timeout_total;
                ok_total = '0;
                crc_fail_total = '0;
                timeout_total = '0;
            end
            default:
                ;
        endcase
        r.port_requested = link_requested();
        r.port_to_partner = partner_owns;
        return r;
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.operation = 3'($urandom_range(0, 7));
        it.data_byte = 8'($urandom_range(0, 255));
        it.byte_corrupt = 1'($urandom_range(0, 1));
        it.response_length = 5'($urandom_range(0, 31));
        return it;
    endfunction

    function automatic dir_row_t stim_row(logic [2:0] op, logic [7:0] b, logic bad,
                                          logic [4:0] len);
        dir_row_t row;
        row = '0;
        row.stim.operation = op;
        row.stim.data_byte = b;
        row.stim.byte_corrupt = bad;
        row.stim.response_length = len;
        return row;
    endfunction

    function automatic dir_row_t reg_row(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
        dir_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic dir_row_t typed_row(dir_row_t row, result_t want);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            link_errors++;
            if (link_errors <= REPORT_LIMIT)
                $display("mismatch on %0s: expected %0h, got %0h at %0t ns",
                         name, want, got, $time);
        end
    endtask

    // Offer one transaction in bursts with random gaps; predict it once accepted.
    task automatic send_item(item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_results.push_back(predict_link(it));
        items_sent++;
        burst_left--;
    endtask

    task automatic send_op(logic [2:0] op);
        item_t it;
        it = noise_item();
        it.operation = op;
        send_item(it);
    endtask

    task automatic send_byte(logic [7:0] b, logic bad);
        item_t it;
        it = noise_item();
        it.operation = OP_BYTE;
        it.data_byte = b;
        it.byte_corrupt = bad;
        send_item(it);
    endtask

    task automatic send_arm(logic [4:0] len);
        item_t it;
        it = noise_item();
        it.operation = OP_ARM;
        it.response_length = len;
        send_item(it);
    endtask

    // Drain everything in flight, then write one register.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_RECEIVE_MODE:
            begin
                mode_bytes = val[0];
                edges_open = '0;
                edges_closed = '0;
                window_age = '0;
                hb_pos = '0;
                hb_valid = 1'b0;
            end
            REG_WINDOW_MS:      window_len = val;
            REG_EDGE_THRESHOLD: edge_limit = val[7:0];
            REG_HB_TIMEOUT:     hb_limit = val;
            REG_TICKS_PER_BYTE: byte_ticks = val[7:0];
            REG_ALLOW_HANDOFF:  handoff_ok = val[0];
            default:            ;
        endcase
    endtask

    task automatic set_link(logic mode, logic [15:0] window, logic [7:0] thr,
                            logic [15:0] hbt, logic [7:0] tpb, logic handoff);
        write_reg(REG_RECEIVE_MODE, {15'd0, mode});
        write_reg(REG_WINDOW_MS, window);
        write_reg(REG_EDGE_THRESHOLD, {8'd0, thr});
        write_reg(REG_HB_TIMEOUT, hbt);
        write_reg(REG_TICKS_PER_BYTE, {8'd0, tpb});
        write_reg(REG_ALLOW_HANDOFF, {15'd0, handoff});
    endtask

    task automatic run_phase(int n_items, bit ok_flood);
        int         start;
        int         pick;
        int         count;
        int         lo;
        int         len;
        int         bad_at;
        logic [7:0] crc;
        logic [7:0] b;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (ok_flood)
            begin
                // pile up zero-length arms to saturate the good-response counter
                if (pick < 98)
                    send_arm(5'd0);
                else
                    send_op(OP_TICK);
            end
            else if (!mode_bytes)
            begin
                if (pick < 70)
                begin
                    lo = (edge_limit > 2) ? int'(edge_limit) - 2 : 0;
                    count = $urandom_range(lo, int'(edge_limit) + 3);
                    repeat (count) send_op(OP_EDGE);
                    if (window_len <= 64)
                        count = (window_age < window_len) ?
                                int'(window_len) - int'(window_age) : 1;
                    else
                        count = $urandom_range(1, 30);
                    repeat (count) send_op(OP_TICK);
                end
                else if (pick < 80)
                    send_op(OP_TICK);
                else if (pick < 90)
                    send_op(OP_STATS);
                else
                    send_item(noise_item());
            end
            else if (pick < 30)
            begin
                bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4;
                if ($urandom_range(0, 3) == 0)
                    send_byte(HB_BYTE0, 1'b0);
                for (int k = 0; k < 4; k++)
                begin
                    if (bad_at != k)
                        send_byte(HEARTBEAT[k], 1'b0);
                    else if ($urandom_range(0, 1) == 0)
                        send_byte(HEARTBEAT[k], 1'b1);
                    else
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            else if (pick < 60)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    len = $urandom_range(RESPONSE_MAX_DEF + 1, 31);
                else if (pick < 3)
                    len = $urandom_range(RESPONSE_MAX_DEF - 1, RESPONSE_MAX_DEF);
                else
                    len = $urandom_range(0, 6);
                send_arm(len[4:0]);
                if (len != 0 && len <= RESPONSE_MAX_DEF)
                begin
                    count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : len;
                    crc = '0;
                    for (int k = 0; k < count; k++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_byte(8'($urandom_range(0, 255)), 1'b1);
                        b = 8'($urandom_range(0, 255));
                        if (k == len - 1 && $urandom_range(0, 9) < 7)
                            b = crc;
                        send_byte(b, 1'b0);
                        crc = crc8_update(crc, b);
                    end
                    // short response: tick on toward the deadline
                    if (count < len)
                    begin
                        count = (byte_ticks <= 4) ? (len + 2) * int'(byte_ticks) + 1 :
                                $urandom_range(1, 12);
                        repeat (count) send_op(OP_TICK);
                    end
                end
            end
            else if (pick < 80)
                repeat ($urandom_range(1, 8)) send_op(OP_TICK);
            else if (pick < 90)
                send_op(OP_STATS);
            else
                send_item(noise_item());
        end
    endtask

    // Receiver: random stall styles, plus one long hold-off to back up the block.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && items_sent >= HOLD_AT_ITEM)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
        begin
            if (rx_phase_left == 0)
            begin
                rx_style <= $urandom_range(0, 2);
                rx_phase_left <= $urandom_range(8, 64);
            end
            else
                rx_phase_left <= rx_phase_left - 1;
            case (rx_style)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                link_errors++;
                if (link_errors <= REPORT_LIMIT)
                    $display("result %h with no transaction waiting at %0t ns", result, $time);
            end
            else
            begin
                popped_want = expected_results.pop_front();
                check_field("port_requested", 8'(popped_want.port_requested),
                            8'(result.port_requested));
                check_field("port_to_partner", 8'(popped_want.port_to_partner),
                            8'(result.port_to_partner));
                check_field("byte_valid", 8'(popped_want.byte_valid), 8'(result.byte_valid));
                check_field("response_byte", popped_want.response_byte, result.response_byte);
                check_field("response_last", 8'(popped_want.response_last),
                            8'(result.response_last));
                check_field("crc_bad", 8'(popped_want.crc_bad), 8'(result.crc_bad));
                check_field("timed_out", 8'(popped_want.timed_out), 8'(result.timed_out));
                check_field("arm_refused", 8'(popped_want.arm_refused),
                            8'(result.arm_refused));
                check_field("ok_count", popped_want.ok_count, result.ok_count);
                check_field("crc_fail_count", popped_want.crc_fail_count, result.crc_fail_count);
                check_field("timeout_count", popped_want.timeout_count, result.timeout_count);
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        mode_bytes = 1'b0;
        window_len = WINDOW_MS_RST;
        edge_limit = EDGE_THRESHOLD_RST;
        hb_limit = HB_TIMEOUT_RST;
        byte_ticks = TICKS_PER_BYTE_RST;
        handoff_ok = 1'b0;
        edges_open = '0;
        edges_closed = '0;
        window_age = '0;
        hb_pos = '0;
        hb_valid = 1'b0;
        hb_age = '0;
        resp_len = '0;
        resp_got = '0;
        resp_crc = '0;
        resp_deadline = '0;
        ok_total = '0;
        crc_fail_total = '0;
        timeout_total = '0;
        partner_owns = 1'b0;

        refused = '0;
        refused.arm_refused = 1'b1;
        handed = '0;
        handed.port_requested = 1'b1;
        handed.port_to_partner = 1'b1;

        // edge mode straight out of reset
        directed.push_back(typed_row(stim_row(OP_STATS, 8'h00, 1'b0, 5'd0), '0));
        directed.push_back(typed_row(stim_row(OP_TICK, 8'h00, 1'b0, 5'd0), '0));
        directed.push_back(typed_row(stim_row(OP_EDGE, 8'h00, 1'b0, 5'd0), '0));
        directed.push_back(typed_row(stim_row(OP_BYTE, 8'hFF, 1'b1, 5'd31), '0));
        directed.push_back(typed_row(stim_row(OP_ARM, 8'h00, 1'b0, 5'd0), refused));
        directed.push_back(typed_row(stim_row(3'd5, 8'hFF, 1'b1, 5'd31), '0));
        // one-tick window, zero threshold, handoff allowed
        directed.push_back(reg_row(REG_WINDOW_MS, 16'd1));
        directed.push_back(reg_row(REG_EDGE_THRESHOLD, 16'd0));
        directed.push_back(reg_row(REG_ALLOW_HANDOFF, 16'd1));
        directed.push_back(stim_row(OP_EDGE, 8'h00, 1'b0, 5'd0));
        directed.push_back(typed_row(stim_row(OP_TICK, 8'h00, 1'b0, 5'd0), handed));
        directed.push_back(stim_row(OP_TICK, 8'h00, 1'b0, 5'd0));
        // byte mode: heartbeat, broken frames, arm cases, deadline
        directed.push_back(reg_row(REG_RECEIVE_MODE, 16'd1));
        directed.push_back(reg_row(REG_HB_TIMEOUT, 16'd3));
        directed.push_back(stim_row(OP_BYTE, HB_BYTE0, 1'b0, 5'd0));
        directed.push_back(stim_row(OP_BYTE, HB_BYTE1, 1'b0, 5'd0));
        directed.push_back(stim_row(OP_BYTE, HB_BYTE2, 1'b0, 5'd0));
        directed.push_back(stim_row(OP_BYTE, HB_BYTE3, 1'b0, 5'd0));
        directed.push_back(stim_row(OP_BYTE, HB_BYTE0, 1'b0, 5'd0));
        directed.push_back(stim_row(OP_BYTE, HB_BYTE0, 1'b0, 5'd0));
        directed.push_back(stim_row(OP_BYTE, HB_BYTE1, 1'b1, 5'd0));
        directed.push_back(stim_row(OP_ARM, 8'h00, 1'b0, 5'd19));
        directed.push_back(stim_row(OP_ARM, 8'h00, 1'b0, 5'd0));
        directed.push_back(stim_row(OP_ARM, 8'h00, 1'b0, 5'd2));
        directed.push_back(stim_row(OP_BYTE, 8'h5A, 1'b0, 5'd0));
        directed.push_back(stim_row(OP_ARM, 8'h00, 1'b0, 5'd1));
        repeat (4) directed.push_back(stim_row(OP_TICK, 8'h00, 1'b0, 5'd0));
        directed.push_back(stim_row(OP_STATS, 8'h00, 1'b0, 5'd0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_reg)
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            else
            begin
                send_item(directed[i].stim);
                // replace the prediction with the hand-written value
                if (directed[i].typed)
                    expected_results[expected_results.size() - 1] = directed[i].want;
            end
        end

        set_link(1'b0, 16'd5, 8'd2, 16'd300, 8'd1, 1'b1);
        run_phase(60, 1'b0);
        set_link(1'b0, 16'd1, 8'd0, 16'd1, 8'd255, 1'b0);
        run_phase(40, 1'b0);
        set_link(1'b0, 16'd65535, 8'd0, 16'd65535, 8'd1, 1'b1);
        run_phase(30, 1'b0);
        set_link(1'b0, 16'd40, 8'd255, 16'd300, 8'd1, 1'b1);
        run_phase(40, 1'b0);
        set_link(1'b1, 16'd200, 8'd2, 16'd20, 8'd1, 1'b1);
        run_phase(80, 1'b0);
        set_link(1'b1, 16'd3, 8'd7, 16'd1, 8'd255, 1'b0);
        run_phase(30, 1'b0);
        set_link(1'b1, 16'd9, 8'd1, 16'd65535, 8'd2, 1'b1);
        run_phase(265, 1'b1);
        set_link(1'b1, 16'd9, 8'd1, 16'd6, 8'd3, 1'b1);
        run_phase(40, 1'b0);
        set_link(1'b0, 16'd3, 8'd1, 16'd50, 8'd1, 1'b1);
        run_phase(30, 1'b0);

        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (link_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
